FILE: sv/ucs_pkg.sv
// ----------------------------------------------------------------------------
// URI component splitter package
// Shared constants, the separator tracking state type and an offset helper.
// ----------------------------------------------------------------------------
package ucs_pkg;

   // Longest URI that is measured; longer strings are flagged.
   localparam int MAX_LEN = 256;

   // Width of a character position, which counts up to MAX_LEN itself.
   localparam int POS_W = $clog2(MAX_LEN + 1);

   // Width of one reported offset field.
   localparam int OFF_W = 9;

   // Width used when narrowing an extended position to an offset field.
   localparam int EXT_W = (POS_W + 1 > OFF_W) ? POS_W + 1 : OFF_W;

   // Packed widths of the stream payloads.
   localparam int REQ_DATA_W = 8;
   localparam int RSP_FIELDS = 9;
   localparam int RSP_DATA_W = ((RSP_FIELDS * OFF_W + 7) / 8) * 8;

   // Characters the splitter looks for.
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_QMARK = 8'h3F;

   // Progress through the "://" separator that follows the first colon.
   typedef enum logic [2:0] {
      PROG_NONE,
      PROG_COLON,
      PROG_SLASH1,
      PROG_SLASH2,
      PROG_SCHEME,
      PROG_FAIL
   } prog_type;

   // Narrow a position (with one guard bit) to an offset field.
   function automatic logic [OFF_W-1:0] to_off(input logic [POS_W:0] v);
      logic [EXT_W-1:0] w;
      w = EXT_W'(v);
      return w[OFF_W-1:0];
   endfunction

endpackage

FILE: sv/uri_component_splitter.sv
// ----------------------------------------------------------------------------
// URI component splitter
// Tracks first-found separators over a URI byte stream and reports the
// scheme, host, port, path and query spans when the last byte arrives.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel carries one URI byte per word; req_tuser marks a
//   word with no byte, so that req_tlast alone can close a string. A word
//   with req_tuser high and req_tlast low is dropped without effect.
//   For every word with req_tlast high one response word is sent, holding
//   nine offsets in rsp_tdata and the too-long flag in rsp_tuser. When the
//   string ran past MAX_LEN bytes all offsets are zero and the flag is set.
//   A word waits in the input register, then is folded into the tracking
//   registers as the response of a last word enters the response register.
//   Throughput: one word per cycle unless a last word waits as told below;
//   a single pass of compare and select logic lies between the input and
//   response registers. Reset clears both pipeline valids, the position
//   counter, the found and overflow flags and the progress state. When the
//   receiver stalls, the response register holds its word and the input
//   register keeps taking bytes that produce no response; a last word waits
//   in the input register until the response register frees.
// ----------------------------------------------------------------------------
module uri_component_splitter
   import ucs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Request stream.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [7:0] uri_char
   input  logic                  req_tuser,   // [0] no_char
   input  logic                  req_tlast,   // last
   // Response stream.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [8:0] scheme_end, [17:9] host_start, [26:18] host_end,
   // [35:27] port_start, [44:36] port_end, [53:45] path_start,
   // [62:54] path_end, [71:63] query_start, [80:72] query_end, rest zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser    // [0] too_long
);

   // Input register.
   logic            s1_valid_ff, s1_valid_in;
   logic [7:0]      s1_char_ff;
   logic            s1_nochar_ff;
   logic            s1_last_ff;

   // Tracking state.
   logic [POS_W-1:0] pos_ff, pos_in, pos_upd;
   logic [POS_W-1:0] qm_ff, qm_in, qm_upd;
   logic             qm_ok_ff, qm_ok_in, qm_ok_upd;
   logic [POS_W-1:0] colon_ff, colon_in, colon_upd;
   logic             colon_ok_ff, colon_ok_in, colon_ok_upd;
   logic [POS_W-1:0] slash_ff, slash_in, slash_upd;
   logic             slash_ok_ff, slash_ok_in, slash_ok_upd;
   logic [POS_W-1:0] sa_ff, sa_in, sa_upd;
   logic             sa_ok_ff, sa_ok_in, sa_ok_upd;
   logic [POS_W-1:0] ca_ff, ca_in, ca_upd;
   logic             ca_ok_ff, ca_ok_in, ca_ok_upd;
   logic             ovf_ff, ovf_in, ovf_upd;
   prog_type         prog_ff, prog_in, prog_upd, prog_step;

   // Response register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_long_ff, rsp_long_in;

   // Handshake control.
   logic out_free;
   logic s1_go;
   logic consume;
   logic take;
   logic emit;
   logic in_range;
   logic is_colon, is_slash, is_qmark;

   // Result arithmetic.
   logic [POS_W:0] len, qv, hs, se, p, col, limit, he, ps, pe, pa, pb;
   logic           scheme, col_ok;

   // Flow control: a word that yields no response never waits.
   always_comb begin
      out_free     = !rsp_valid_ff || rsp_tready;
      s1_go        = !s1_last_ff || out_free;
      consume      = s1_valid_ff && s1_go;
      take         = consume && !s1_nochar_ff;
      emit         = consume && s1_last_ff;
      req_tready   = !s1_valid_ff || s1_go;
      s1_valid_in  = (req_tvalid && req_tready) ? 1'b1 : (consume ? 1'b0 : s1_valid_ff);
      rsp_valid_in = emit ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   // Character classes of the word being consumed.
   always_comb begin
      is_colon = s1_char_ff == CHAR_COLON;
      is_slash = s1_char_ff == CHAR_SLASH;
      is_qmark = s1_char_ff == CHAR_QMARK;
      in_range = pos_ff < POS_W'(MAX_LEN);
   end

   // Separator progress next state: "://" after the first colon.
   always_comb begin
      unique case (prog_ff)
         PROG_COLON:  prog_step = is_slash ? PROG_SLASH1 : PROG_FAIL;
         PROG_SLASH1: prog_step = is_slash ? PROG_SLASH2 : PROG_FAIL;
         PROG_SLASH2: prog_step = PROG_SCHEME;
         default:     prog_step = prog_ff;
      endcase
      prog_upd = prog_ff;
      if (take && in_range) begin
         prog_upd = prog_step;
         if (is_colon && !colon_ok_ff) begin
            prog_upd = PROG_COLON;
         end
      end
      prog_in = emit ? PROG_NONE : prog_upd;
   end

   // First-found positions after taking the current byte.
   always_comb begin
      pos_upd      = pos_ff;
      qm_upd       = qm_ff;
      qm_ok_upd    = qm_ok_ff;
      colon_upd    = colon_ff;
      colon_ok_upd = colon_ok_ff;
      slash_upd    = slash_ff;
      slash_ok_upd = slash_ok_ff;
      sa_upd       = sa_ff;
      sa_ok_upd    = sa_ok_ff;
      ca_upd       = ca_ff;
      ca_ok_upd    = ca_ok_ff;
      ovf_upd      = ovf_ff;
      if (take) begin
         if (!in_range) begin
            ovf_upd = 1'b1;
         end else begin
            if (prog_step == PROG_SCHEME) begin
               if (is_slash && !sa_ok_ff) begin
                  sa_upd    = pos_ff;
                  sa_ok_upd = 1'b1;
               end
               if (is_colon && !ca_ok_ff) begin
                  ca_upd    = pos_ff;
                  ca_ok_upd = 1'b1;
               end
            end
            if (is_colon && !colon_ok_ff) begin
               colon_upd    = pos_ff;
               colon_ok_upd = 1'b1;
            end
            if (is_qmark && !qm_ok_ff) begin
               qm_upd    = pos_ff;
               qm_ok_upd = 1'b1;
            end
            if (is_slash && !slash_ok_ff) begin
               slash_upd    = pos_ff;
               slash_ok_upd = 1'b1;
            end
            pos_upd = pos_ff + POS_W'(1);
         end
      end
   end

   // The position counter, found flags and overflow flag clear after the last word of a string.
   always_comb begin
      pos_in      = emit ? '0 : pos_upd;
      qm_in       = qm_upd;
      qm_ok_in    = emit ? 1'b0 : qm_ok_upd;
      colon_in    = colon_upd;
      colon_ok_in = emit ? 1'b0 : colon_ok_upd;
      slash_in    = slash_upd;
      slash_ok_in = emit ? 1'b0 : slash_ok_upd;
      sa_in       = sa_upd;
      sa_ok_in    = emit ? 1'b0 : sa_ok_upd;
      ca_in       = ca_upd;
      ca_ok_in    = emit ? 1'b0 : ca_ok_upd;
      ovf_in      = emit ? 1'b0 : ovf_upd;
   end

   // Span computation from the updated tracking state.
   always_comb begin
      len    = {1'b0, pos_upd};
      qv     = qm_ok_upd ? {1'b0, qm_upd} : len;
      scheme = prog_upd == PROG_SCHEME;
      se     = scheme ? {1'b0, colon_upd} : '0;
      hs     = scheme ? ({1'b0, colon_upd} + (POS_W + 1)'(3)) : '0;
      if (scheme) begin
         p      = sa_ok_upd ? {1'b0, sa_upd} : len;
         col_ok = ca_ok_upd;
         col    = {1'b0, ca_upd};
      end else begin
         p      = slash_ok_upd ? {1'b0, slash_upd} : len;
         col_ok = colon_ok_upd;
         col    = {1'b0, colon_upd};
      end
      limit = (p < len) ? p : qv;

      // Host and port: empty at host start when it lies past its limit.
      priority if (hs > limit) begin
         he = hs;
         ps = hs;
         pe = hs;
      end else if (col_ok && col >= hs && col < limit) begin
         he = col;
         ps = col + (POS_W + 1)'(1);
         pe = limit;
      end else begin
         he = limit;
         ps = limit;
         pe = limit;
      end

      // Path: empty at its slash when the query mark comes first.
      if (p < len) begin
         pa = p;
         pb = (qv >= p) ? qv : p;
      end else begin
         pa = qv;
         pb = qv;
      end

      if (ovf_upd) begin
         rsp_data_in = '0;
         rsp_long_in = 1'b1;
      end else begin
         rsp_data_in = RSP_DATA_W'({to_off(len), to_off(qv), to_off(pb), to_off(pa),
                                   to_off(pe), to_off(ps), to_off(he), to_off(hs),
                                   to_off(se)});
         rsp_long_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= '0;
         qm_ok_ff     <= 1'b0;
         colon_ok_ff  <= 1'b0;
         slash_ok_ff  <= 1'b0;
         sa_ok_ff     <= 1'b0;
         ca_ok_ff     <= 1'b0;
         ovf_ff       <= 1'b0;
         prog_ff      <= PROG_NONE;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
         qm_ok_ff     <= qm_ok_in;
         colon_ok_ff  <= colon_ok_in;
         slash_ok_ff  <= slash_ok_in;
         sa_ok_ff     <= sa_ok_in;
         ca_ok_ff     <= ca_ok_in;
         ovf_ff       <= ovf_in;
         prog_ff      <= prog_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_char_ff   <= req_tdata;
         s1_nochar_ff <= req_tuser;
         s1_last_ff   <= req_tlast;
      end
      if (emit) begin
         rsp_data_ff <= rsp_data_in;
         rsp_long_ff <= rsp_long_in;
      end
      qm_ff    <= qm_in;
      colon_ff <= colon_in;
      slash_ff <= slash_in;
      sa_ff    <= sa_in;
      ca_ff    <= ca_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_long_ff;

endmodule
